// ----- rtl/core/signed_integer_to_decimal_ascii_unit_macros.svh -----
// Assertion macros shared by the decimal text converter.
`ifndef SIGNED_INTEGER_TO_DECIMAL_ASCII_UNIT_MACROS_SVH
`define SIGNED_INTEGER_TO_DECIMAL_ASCII_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SIDA_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("Converter assertion failed.");

// The consequent must hold in the cycle after the antecedent.
`define SIDA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("Converter assertion failed.");

`endif

// ----- rtl/core/sida_pkg.sv -----
// Shared types, constants and helpers for the decimal text converter.
`timescale 1ns / 1ps

package sida_pkg;

    localparam int VALUE_BITS_DEFAULT = 32;
    localparam int BCD_W = 4;
    localparam logic [7:0] MINUS_CODE = 8'd45;
    localparam logic [7:0] DIGIT_BASE = 8'd48;

    typedef struct packed {
        logic clear;
        logic conv;
        logic shift;
    } t_cell_ctrl;

    // Number of decimal digits that covers any value of the given bit width.
    function automatic int num_digits(input int bits);
        return ((bits * 1233) >> 12) + 1;
    endfunction

endpackage

// ----- rtl/core/sida_digit_cell.sv -----
// One BCD digit cell of the shift-and-add-three chain.
`timescale 1ns / 1ps

module sida_digit_cell (
    input  logic                       i_clk,
    input  sida_pkg::t_cell_ctrl       i_ctrl,
    input  logic                       i_bit,
    input  logic [sida_pkg::BCD_W-1:0] i_digit,
    output logic [sida_pkg::BCD_W-1:0] o_digit,
    output logic                       o_carry
);

    logic [sida_pkg::BCD_W-1:0] r_digit;
    logic [sida_pkg::BCD_W-1:0] n_digit;
    logic [sida_pkg::BCD_W-1:0] w_adj;

    assign w_adj   = (r_digit >= 4'd5) ? r_digit + 4'd3 : r_digit;
    assign o_carry = w_adj[sida_pkg::BCD_W-1];
    assign o_digit = r_digit;

    always_comb begin
        n_digit = r_digit;
        if (i_ctrl.clear) begin
            n_digit = '0;
        end else if (i_ctrl.conv) begin
            n_digit = {w_adj[sida_pkg::BCD_W-2:0], i_bit};
        end else if (i_ctrl.shift) begin
            n_digit = i_digit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

endmodule

// ----- rtl/core/signed_integer_to_decimal_ascii_unit.sv -----
// Signed integer to decimal ASCII converter, one character per strobe, sign first.
// Sequence: shift-and-add-three through the digit chain, then a '-' character when
// negative, then the digit chain shifts out.
// Busy, and taking no new start, until the last digit has shifted out. Results cannot stall.
// Synchronous active-low reset returns the controller to idle with no output pending.
`timescale 1ns / 1ps

`include "signed_integer_to_decimal_ascii_unit_macros.svh"

module signed_integer_to_decimal_ascii_unit #(
    parameter int VALUE_BITS = sida_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  logic [VALUE_BITS-1:0] i_value,
    output logic                  busy,
    output logic                  o_strobe,
    output logic [7:0]            o_char_code,
    output logic                  o_last_char
);

    localparam int NDIG   = sida_pkg::num_digits(VALUE_BITS);
    localparam int CNT_W  = $clog2(VALUE_BITS + 1);
    localparam int LEFT_W = $clog2(NDIG + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CONV = 4'b0010,
        S_SIGN = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state                r_state, n_state;
    logic [VALUE_BITS-1:0] r_mag, n_mag;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [LEFT_W-1:0]     r_left, n_left;
    logic                  r_neg, n_neg;
    logic                  r_seen, n_seen;
    logic                  r_strobe, n_strobe;
    logic [7:0]            r_char, n_char;
    logic                  r_last, n_last;

    sida_pkg::t_cell_ctrl       w_ctrl;
    logic [sida_pkg::BCD_W-1:0] w_digit [NDIG];
    logic                       w_carry [NDIG];
    logic [sida_pkg::BCD_W-1:0] w_top;
    logic                       w_accept;

    assign w_accept = start && (r_state == S_IDLE);
    assign w_top    = w_digit[NDIG-1];

    genvar g;
    generate
        for (g = 0; g < NDIG; g++) begin : g_cell
            if (g == 0) begin : g_first
                sida_digit_cell u_cell (
                    .i_clk   (i_clk),
                    .i_ctrl  (w_ctrl),
                    .i_bit   (r_mag[VALUE_BITS-1]),
                    .i_digit ('0),
                    .o_digit (w_digit[g]),
                    .o_carry (w_carry[g])
                );
            end else begin : g_rest
                sida_digit_cell u_cell (
                    .i_clk   (i_clk),
                    .i_ctrl  (w_ctrl),
                    .i_bit   (w_carry[g-1]),
                    .i_digit (w_digit[g-1]),
                    .o_digit (w_digit[g]),
                    .o_carry (w_carry[g])
                );
            end
        end
    endgenerate

    always_comb begin
        n_state  = r_state;
        n_mag    = r_mag;
        n_cnt    = r_cnt;
        n_left   = r_left;
        n_neg    = r_neg;
        n_seen   = r_seen;
        n_strobe = 1'b0;
        n_char   = r_char;
        n_last   = r_last;
        w_ctrl   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    w_ctrl.clear = 1'b1;
                    n_neg   = i_value[VALUE_BITS-1];
                    n_mag   = i_value[VALUE_BITS-1] ? (~i_value + 1'b1) : i_value;
                    n_cnt   = CNT_W'(VALUE_BITS);
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                w_ctrl.conv = 1'b1;
                n_mag = r_mag << 1;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    n_left  = LEFT_W'(NDIG);
                    n_seen  = 1'b0;
                    n_state = r_neg ? S_SIGN : S_EMIT;
                end
            end
            S_SIGN: begin
                n_strobe = 1'b1;
                n_char   = sida_pkg::MINUS_CODE;
                n_last   = 1'b0;
                n_state  = S_EMIT;
            end
            S_EMIT: begin
                w_ctrl.shift = 1'b1;
                n_left = r_left - 1'b1;
                if (r_seen || (w_top != '0) || (r_left == LEFT_W'(1))) begin
                    n_seen   = 1'b1;
                    n_strobe = 1'b1;
                    n_char   = sida_pkg::DIGIT_BASE + {4'b0000, w_top};
                    n_last   = (r_left == LEFT_W'(1));
                end
                if (r_left == LEFT_W'(1)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
        r_mag  <= n_mag;
        r_cnt  <= n_cnt;
        r_left <= n_left;
        r_neg  <= n_neg;
        r_seen <= n_seen;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign busy        = (r_state != S_IDLE);
    assign o_strobe    = r_strobe;
    assign o_char_code = r_char;
    assign o_last_char = r_last;

    `SIDA_ASSERT_NEXT(a_accept_starts_conv, w_accept, r_state == S_CONV)
    `SIDA_ASSERT_NEXT(a_nothing_after_last, o_strobe && o_last_char, !o_strobe)
    `SIDA_ASSERT_SAME(a_minus_not_last, o_strobe && (o_char_code == sida_pkg::MINUS_CODE),
                      !o_last_char)
    `SIDA_ASSERT_SAME(a_state_onehot, 1'b1, $onehot(r_state))

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for the signed integer to decimal ASCII converter.
`timescale 1ns / 1ps

module tb_top;

    localparam int          CLK_PERIOD    = 20;
    localparam int          RANDOM_ITEMS  = 210;
    localparam int          CYCLE_LIMIT   = 200000;
    localparam int          SETTLE_CYCLES = 60;
    localparam int          MAX_REPORTS   = 10;
    localparam logic [31:0] RADIX         = 32'd10;

    typedef struct {
        logic [31:0] value;
        string       text;
    } t_directed_row;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } t_char_expect;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic [31:0] i_value;
    logic        busy;
    logic        o_strobe;
    logic [7:0]  o_char_code;
    logic        o_last_char;

    logic [7:0]   request_chars[$];
    int           request_lengths[$];
    t_char_expect awaited_chars[$];

    int mismatches     = 0;
    int chars_checked  = 0;
    int items_accepted = 0;
    int cycle_count    = 0;

    // An empty text means the row is checked against the predictor.
    t_directed_row directed_rows[] = '{
        '{32'sd0,           "0"},
        '{32'sd1,           "1"},
        '{-32'sd1,          "-1"},
        '{32'sd9,           "9"},
        '{32'sd10,          "10"},
        '{-32'sd10,         "-10"},
        '{32'sd99,          "99"},
        '{32'sd100,         "100"},
        '{-32'sd100,        "-100"},
        '{32'sd2147483647,  "2147483647"},
        '{32'h8000_0000,    "-2147483648"},
        '{-32'sd2147483647, "-2147483647"},
        '{32'sd1000000000,  "1000000000"},
        '{32'sd999999999,   "999999999"},
        '{-32'sd999999999,  "-999999999"},
        '{32'sd123456789,   "123456789"},
        '{32'h5555_5555,    ""},
        '{32'hAAAA_AAAA,    ""},
        '{32'h0000_FFFF,    ""},
        '{32'hFFFF_0000,    ""}
    };

    signed_integer_to_decimal_ascii_unit #(
        .VALUE_BITS(32)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_value    (i_value),
        .busy       (busy),
        .o_strobe   (o_strobe),
        .o_char_code(o_char_code),
        .o_last_char(o_last_char)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    task automatic note_mismatch(input string what);
        if (mismatches < MAX_REPORTS) begin
            $display("MISMATCH at cycle %0d: %s", cycle_count, what);
        end
        mismatches++;
    endtask

    task automatic queue_decimal_text(input logic [31:0] value);
        logic [31:0] magnitude;
        logic [7:0]  digits[$];
        int          count;
        magnitude = value[31] ? -value : value;
        do begin
            digits.push_front(sida_pkg::DIGIT_BASE + 8'(magnitude % RADIX));
            magnitude = magnitude / RADIX;
        end while (magnitude != 0);
        count = digits.size();
        if (value[31]) begin
            request_chars.push_back(sida_pkg::MINUS_CODE);
            count++;
        end
        foreach (digits[i]) request_chars.push_back(digits[i]);
        request_lengths.push_back(count);
    endtask

    task automatic queue_typed_text(input string text);
        for (int i = 0; i < text.len(); i++) request_chars.push_back(text[i]);
        request_lengths.push_back(text.len());
    endtask

    function automatic int next_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [31:0] pick_value();
        logic [31:0] value;
        logic [31:0] power;
        int          exponent;
        case ($urandom_range(0, 5))
            0: value = $urandom();
            1: value = $urandom_range(0, 999);
            2: begin
                exponent = $urandom_range(0, 9);
                power = 1;
                repeat (exponent) power = power * RADIX;
                value = power - 1 + $urandom_range(0, 2);
            end
            3: value = 32'h7FFF_FFFF - $urandom_range(0, 3);
            4: value = 32'h8000_0000 + $urandom_range(0, 3);
            default: value = $urandom() >> $urandom_range(0, 31);
        endcase
        if ($urandom_range(0, 1) == 1) value = -value;
        return value;
    endfunction

    // Called at a rising edge; returns at the edge that accepts the request.
    task automatic issue_request(input logic [31:0] value, input string text, input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        if (text.len() == 0) begin
            queue_decimal_text(value);
        end else begin
            queue_typed_text(text);
        end
        start   <= 1'b1;
        i_value <= value;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (request_lengths.size() != 0 || awaited_chars.size() != 0);
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles.", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin : char_monitor
        int           count;
        t_char_expect want;
        if (i_rst_n) begin
            if (start && !busy) begin
                if (request_lengths.size() == 0) begin
                    note_mismatch("request accepted while none was offered");
                end else begin
                    count = request_lengths.pop_front();
                    for (int k = 0; k < count; k++) begin
                        awaited_chars.push_back('{code: request_chars.pop_front(),
                                                  last: (k == count - 1)});
                    end
                    items_accepted++;
                end
            end
            if (o_strobe === 1'b1) begin
                if (awaited_chars.size() == 0) begin
                    note_mismatch($sformatf("unexpected character 0x%02h last %b",
                                            o_char_code, o_last_char));
                end else begin
                    want = awaited_chars.pop_front();
                    chars_checked++;
                    if (o_char_code !== want.code || o_last_char !== want.last) begin
                        note_mismatch($sformatf("expected 0x%02h last %b, got 0x%02h last %b",
                                                want.code, want.last, o_char_code,
                                                o_last_char));
                    end
                end
            end
        end
    end

    initial begin
        start   <= 1'b0;
        i_value <= '0;
        i_rst_n <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            issue_request(directed_rows[i].value, directed_rows[i].text, next_gap());
        end

        // Let the converter run completely dry before the random requests.
        wait_drained();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            issue_request(pick_value(), "", ((n % 50) < 12) ? 0 : next_gap());
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (request_lengths.size() != 0 || awaited_chars.size() != 0) begin
            note_mismatch($sformatf("%0d characters never arrived", awaited_chars.size()));
        end

        $display("Converted %0d integers (%0d directed, %0d random) into %0d characters.",
                 items_accepted, directed_rows.size(), RANDOM_ITEMS, chars_checked);
        $display("Covered zero, both extremes, powers of ten and random gaps; %0d mismatches.",
                 mismatches);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/sida_pkg.sv
rtl/core/sida_digit_cell.sv
rtl/core/signed_integer_to_decimal_ascii_unit.sv
dv/tb_top.sv
